// ===== hdl/ffsm_pkg.sv =====
// ffsm_pkg: shared types and constants of the foot force stability margin block
// used by ffsm_leg_bank and foot_force_stability_margin_core
// no dependencies
package ffsm_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// operation index walked by the sequencer
	localparam int OP_W = 4;
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_LEG_LAST  = 4'd3;  // ops 0..3 multiply the product by a leg force
	localparam op_t OP_SCALE     = 4'd4;  // multiply the product by n^n
	localparam op_t OP_DEN_FIRST = 4'd5;  // ops 5..8 raise the sum to the n-th power
	localparam op_t OP_DIV       = 4'd9;  // start the restoring division

	// item kinds carried on tuser
	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// legs
	localparam int NUM_LEGS = 4;
	localparam int LEG_W    = 2;
	localparam int LOADED_W = 3;
	localparam logic [LOADED_W-1:0] MIN_LOADED = 3'd3;

	// n^n factors for three and four loaded legs
	localparam int SCALE_W = 9;
	localparam logic [SCALE_W-1:0] SCALE_THREE = 9'd27;
	localparam logic [SCALE_W-1:0] SCALE_FOUR  = 9'd256;

	// result format
	localparam int FRAC_BITS   = 16;
	localparam int MARGIN_W    = 17;
	localparam int QUOT_STEPS  = 17;
	localparam logic [MARGIN_W-1:0] MARGIN_ONE = 17'h10000;
	localparam int M_DATA_W    = 24;
	localparam int M_PAD_W     = M_DATA_W - MARGIN_W - LOADED_W;

	// write command into the leg bank
	typedef struct packed {
		logic             en;
		logic [LEG_W-1:0] leg;
	} leg_wr_t;

endpackage

// ===== hdl/ffsm_addsub.sv =====
// ffsm_addsub: the shared wide adder / subtractor of the margin block
// used for the shift-add multiplies and the restoring division steps
// no dependencies
module ffsm_addsub #(
	parameter int W = 88
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] res,
	output logic         carry_out
);

	// carry_out is the carry of an add and the borrow of a subtract
	always_comb begin
		if (sub) begin
			{carry_out, res} = {1'b0, a} - {1'b0, b};
		end else begin
			{carry_out, res} = {1'b0, a} + {1'b0, b};
		end
	end

endmodule

// ===== hdl/ffsm_leg_bank.sv =====
// ffsm_leg_bank: latest force sample of each leg, loaded count and loaded sum
// depends on ffsm_pkg
module ffsm_leg_bank #(
	parameter int FORCE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ffsm_pkg::leg_wr_t                wr,
	input  logic signed [FORCE_BITS-1:0]     wr_force,
	input  logic [ffsm_pkg::LEG_W-1:0]       sel,
	output logic [FORCE_BITS-1:0]            sel_force,
	output logic                             sel_loaded,
	output logic [ffsm_pkg::LOADED_W-1:0]    loaded_cnt,
	output logic [FORCE_BITS:0]              loaded_sum
);

	import ffsm_pkg::*;

	logic signed [FORCE_BITS-1:0] force_q [NUM_LEGS];
	logic [NUM_LEGS-1:0]          loaded;

	// force registers, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEGS; i++) begin
				force_q[i] <= '0;
			end
		end else if (wr.en) begin
			force_q[wr.leg] <= wr_force;
		end
	end

	// a leg is loaded when its force is above zero
	always_comb begin
		for (int i = 0; i < NUM_LEGS; i++) begin
			loaded[i] = !force_q[i][FORCE_BITS-1] && (|force_q[i]);
		end
	end

	// count and sum of the loaded legs
	always_comb begin
		loaded_cnt = '0;
		loaded_sum = '0;
		for (int i = 0; i < NUM_LEGS; i++) begin
			loaded_cnt = loaded_cnt + {{(LOADED_W-1){1'b0}}, loaded[i]};
			if (loaded[i]) begin
				loaded_sum = loaded_sum + {1'b0, force_q[i]};
			end
		end
	end

	// leg picked by the sequencer
	assign sel_force  = force_q[sel];
	assign sel_loaded = loaded[sel];

endmodule

// ===== hdl/foot_force_stability_margin_core.sv =====
// Foot force stability margin: keeps one signed force per leg of a four-legged
// walker and, on a tick beat, gives the margin prod(f) * n^n / sum(f)^n in
// unsigned Q1.16 (65536 = 1.0, truncated) with the loaded-leg count. Store beats
// give no result. A tick with fewer than three loaded legs goes straight to the
// result; otherwise the single shared wide adder runs every bit of the shift-add
// multiplies and the 17 steps of the restoring division. The block takes no beat
// while a tick is in work.
// depends on ffsm_pkg, ffsm_leg_bank, ffsm_addsub
module foot_force_stability_margin_core #(
	parameter int FORCE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// leg [1:0], force_value [FORCE_BITS+1:2], zero fill
	input  logic [((FORCE_BITS+9)/8)*8-1:0]      s_tdata,
	// kind
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// margin [16:0], loaded_legs [19:17], zero fill
	output logic [ffsm_pkg::M_DATA_W-1:0]        m_tdata
);

	import ffsm_pkg::*;

	localparam int MW       = FORCE_BITS + 1;
	localparam int W        = 4 * FORCE_BITS + 24;
	localparam int STEP_MAX = (MW > QUOT_STEPS) ? MW : QUOT_STEPS;
	localparam int CNT_W    = $clog2(STEP_MAX + 1);

	state_t                  state_q, state_d;
	op_t                     op_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [MW-1:0]           mplr_q;
	logic [W-1:0]            num_q, den_q, acc_q;
	logic                    tgt_den_q;
	logic [MARGIN_W-1:0]     quot_q, margin_q;
	logic [LOADED_W-1:0]     n_q, loaded_q;
	logic [FORCE_BITS:0]     sum_q;
	logic                    out_valid_q;

	logic                    s_fire, tick_fire, load_out, op_active, cnt_last;
	logic [LEG_W-1:0]        s_leg;
	logic signed [FORCE_BITS-1:0] s_force;
	leg_wr_t                 leg_wr;
	logic [FORCE_BITS-1:0]   sel_force;
	logic                    sel_loaded;
	logic [LOADED_W-1:0]     loaded_cnt;
	logic [FORCE_BITS:0]     loaded_sum;
	logic [MW-1:0]           mult_src;
	logic [W-1:0]            unit_a, unit_b, unit_res, mul_x;
	logic                    unit_sub, unit_carry;
	op_t                     den_step;

	// input beat fields
	assign s_leg     = s_tdata[LEG_W-1:0];
	assign s_force   = s_tdata[FORCE_BITS+LEG_W-1:LEG_W];
	assign s_fire    = s_tvalid && s_tready;
	assign tick_fire = s_fire && (s_tuser == KIND_TICK);

	assign leg_wr.en  = s_fire && (s_tuser == KIND_STORE);
	assign leg_wr.leg = s_leg;

	ffsm_leg_bank #(
		.FORCE_BITS (FORCE_BITS)
	) u_leg_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (leg_wr),
		.wr_force   (s_force),
		.sel        (op_q[LEG_W-1:0]),
		.sel_force  (sel_force),
		.sel_loaded (sel_loaded),
		.loaded_cnt (loaded_cnt),
		.loaded_sum (loaded_sum)
	);

	ffsm_addsub #(
		.W (W)
	) u_addsub (
		.a         (unit_a),
		.b         (unit_b),
		.sub       (unit_sub),
		.res       (unit_res),
		.carry_out (unit_carry)
	);

	// which operations of the sequence run, and their multiplier
	assign den_step = op_q - OP_DEN_FIRST;
	assign cnt_last = (cnt_q == CNT_W'(1));

	always_comb begin
		op_active = 1'b0;
		mult_src  = sum_q;
		if (op_q <= OP_LEG_LAST) begin
			op_active = sel_loaded;
			mult_src  = {1'b0, sel_force};
		end else if (op_q == OP_SCALE) begin
			op_active = 1'b1;
			mult_src  = (n_q == MIN_LOADED) ? MW'(SCALE_THREE) : MW'(SCALE_FOUR);
		end else if (op_q < OP_DIV) begin
			op_active = (den_step < {1'b0, n_q});
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_fire) begin
					state_d = (loaded_cnt < MIN_LOADED) ? ST_DONE : ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (op_q == OP_DIV) begin
					state_d = ST_DIV;
				end else if (op_active) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_last) begin
					state_d = ST_NEXT;
				end
			end
			ST_DIV: begin
				if (cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and shared unit operands
	assign mul_x = tgt_den_q ? den_q : num_q;

	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		unit_a   = '0;
		unit_b   = '0;
		unit_sub = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL: begin
				unit_a = acc_q << 1;
				unit_b = mplr_q[MW-1] ? mul_x : '0;
			end
			ST_DIV: begin
				unit_a   = num_q;
				unit_b   = den_q;
				unit_sub = 1'b1;
			end
			ST_DONE: load_out = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_fire) begin
						op_q <= '0;
					end
				end
				ST_NEXT: begin
					if (op_q == OP_DIV) begin
						cnt_q <= CNT_W'(QUOT_STEPS);
					end else if (op_active) begin
						cnt_q <= CNT_W'(MW);
					end else begin
						op_q <= op_q + op_t'(1);
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_last) begin
						op_q <= op_q + op_t'(1);
					end
				end
				ST_DIV: cnt_q <= cnt_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (tick_fire) begin
					n_q    <= loaded_cnt;
					sum_q  <= loaded_sum;
					num_q  <= W'(1);
					den_q  <= W'(1);
					quot_q <= '0;
				end
			end
			ST_NEXT: begin
				if (op_q == OP_DIV) begin
					num_q <= num_q << FRAC_BITS;
					den_q <= den_q << FRAC_BITS;
				end else if (op_active) begin
					acc_q     <= '0;
					mplr_q    <= mult_src;
					tgt_den_q <= (op_q >= OP_DEN_FIRST);
				end
			end
			// shift-add multiply, multiplier msb first
			ST_MUL: begin
				acc_q  <= unit_res;
				mplr_q <= mplr_q << 1;
				if (cnt_last) begin
					if (tgt_den_q) begin
						den_q <= unit_res;
					end else begin
						num_q <= unit_res;
					end
				end
			end
			// restoring division, one quotient bit per cycle
			ST_DIV: begin
				if (!unit_carry) begin
					num_q <= unit_res;
				end
				quot_q <= {quot_q[MARGIN_W-2:0], !unit_carry};
				den_q  <= den_q >> 1;
			end
			ST_DONE: begin
				if (load_out) begin
					margin_q <= quot_q;
					loaded_q <= n_q;
				end
			end
			default: ;
		endcase
	end

	// result beat
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, loaded_q, margin_q};

	// checks
	a_margin_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (margin_q <= MARGIN_ONE))
		else $error("margin above 1.0");

	a_few_legs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (loaded_q < MIN_LOADED)) |-> (margin_q == '0))
		else $error("nonzero margin with fewer than three loaded legs");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != '0))
		else $error("division by zero sum");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> ((cnt_q != '0) && (cnt_q <= CNT_W'(MW))))
		else $error("multiply step count out of range");

endmodule
